/* sv/gbp_pkg.sv */
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants of the gselect branch predictor: field widths,
// operation codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package gbp_pkg;

  // Field widths fixed by the item format.
  localparam int HistW     = 11;
  localparam int AddrW     = 48;
  localparam int ModeW     = 3;
  localparam int ThreadW   = 2;
  localparam int PcShiftW  = 3;
  localparam int HistLenW  = 4;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 4;

  // Operation codes carried by the mode field.
  localparam logic [ModeW-1:0] ModeLookup  = 3'd0;
  localparam logic [ModeW-1:0] ModeUncond  = 3'd1;
  localparam logic [ModeW-1:0] ModeResolve = 3'd2;
  localparam logic [ModeW-1:0] ModeRestore = 3'd3;
  localparam logic [ModeW-1:0] ModeBtbMiss = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPcShift = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHistLen = 1'b1;

  // Configuration reset values.
  localparam logic [PcShiftW-1:0] PcShiftRst = 3'd2;
  localparam logic [HistLenW-1:0] HistLenRst = 4'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write zero to the next table entry of the clearing pass
    logic capture;  // register an accepted input item
    logic read;     // compute the table index and read the counter
    logic commit;   // update state and load the result register
  } gbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is at the last entry
    logic out_full;  // the result register holds an item that is not taken
  } gbp_sts_t;

endpackage

`default_nettype wire

/* sv/gbp_ctrl.sv */
// ----------------------------------------------------------------------------
// gbp_ctrl
// Sequencer of the predictor: runs the table clearing pass after reset, then
// takes one item at a time through accept, table read and update.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gbp_pkg::gbp_sts_t sts_i,
  output gbp_pkg::gbp_cmd_t      cmd_o
);
  import gbp_pkg::*;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StRead,
    StExec
  } state_e;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StExec;
      end
      StExec: begin
        if (!sts_i.out_full) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from the state.
  assign in_ready_o     = (state_q == StIdle);
  assign cmd_o.clear    = (state_q == StClear);
  assign cmd_o.capture  = (state_q == StIdle) && in_valid_i;
  assign cmd_o.read     = (state_q == StRead);
  assign cmd_o.commit   = (state_q == StExec) && !sts_i.out_full;

endmodule

`default_nettype wire

/* sv/gbp_datapath.sv */
// ----------------------------------------------------------------------------
// gbp_datapath
// Item registers, per-thread history, configuration, the counter table and
// the result register of the predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_datapath #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int COUNTER_BITS  = 2,
  parameter int THREADS       = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gbp_pkg::gbp_cmd_t             cmd_i,
  output gbp_pkg::gbp_sts_t                  sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [gbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gbp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [gbp_pkg::ModeW-1:0]     mode_i,
  input  wire logic [gbp_pkg::ThreadW-1:0]   thread_i,
  input  wire logic [gbp_pkg::AddrW-1:0]     branch_addr_i,
  input  wire logic                          taken_i,
  input  wire logic                          squashed_i,
  input  wire logic [gbp_pkg::HistW-1:0]     saved_history_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               predict_taken_o,
  output logic [gbp_pkg::HistW-1:0]          history_snapshot_o
);
  import gbp_pkg::*;

  // Index width is floor(log2(TABLE_ENTRIES)).
  localparam int IdxW    = $clog2(TABLE_ENTRIES + 1) - 1;
  localparam int Depth   = 2 ** IdxW;
  localparam int ThrW    = (THREADS > 1) ? $clog2(THREADS) : 1;

  // Captured item.
  logic [ModeW-1:0]   mode_q;
  logic [ThreadW-1:0] thread_q;
  logic [AddrW-1:0]   addr_q;
  logic               taken_q;
  logic               squashed_q;
  logic [HistW-1:0]   saved_q;

  // Configuration.
  logic [PcShiftW-1:0] pc_shift_q;
  logic [HistLenW-1:0] hist_len_q;

  // State.
  logic [HistW-1:0]        hist_q [THREADS];
  logic [COUNTER_BITS-1:0] mem [Depth];
  logic [COUNTER_BITS-1:0] rd_q;
  logic [IdxW-1:0]         idx_q;
  logic [IdxW-1:0]         clr_cnt_q;

  // Result register.
  logic             out_valid_q;
  logic             pred_q;
  logic [HistW-1:0] snap_q;

  logic                    thread_ok;
  logic [ThrW-1:0]         thr;
  logic [HistW-1:0]        hist_cur;
  logic [HistLenW-1:0]     h_eff;
  logic [HistW-1:0]        hmask;
  logic [HistW-1:0]        n_src;
  logic [AddrW-1:0]        addr_sh;
  logic [IdxW-1:0]         m_sh;
  logic [IdxW-1:0]         idx;
  logic                    pred;
  logic [HistW-1:0]        hist_new;
  logic                    hist_we;
  logic                    train;
  logic [COUNTER_BITS-1:0] cnt_new;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [COUNTER_BITS-1:0] mem_wdata;

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= mode_i;
      thread_q   <= thread_i;
      addr_q     <= branch_addr_i;
      taken_q    <= taken_i;
      squashed_q <= squashed_i;
      saved_q    <= saved_history_i;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_shift_q <= PcShiftRst;
      hist_len_q <= HistLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPcShift: pc_shift_q <= cfg_data_i[PcShiftW-1:0];
        CfgHistLen: hist_len_q <= cfg_data_i[HistLenW-1:0];
        default: ;
      endcase
    end
  end

  // Current thread's history; threads beyond the configured count read as zero.
  assign thread_ok = (int'(thread_q) < THREADS);
  assign thr       = ThrW'(thread_q);
  assign hist_cur  = thread_ok ? hist_q[thr] : '0;

  // Effective history length is limited by the history width and index width.
  always_comb begin
    h_eff = hist_len_q;
    if (int'(h_eff) > HistW) begin
      h_eff = HistLenW'(HistW);
    end
    if (int'(h_eff) > IdxW) begin
      h_eff = HistLenW'(IdxW);
    end
  end

  assign hmask = ~({HistW{1'b1}} << h_eff);

  // Table index: shifted address bits above the masked history bits.
  assign n_src   = (mode_q == ModeResolve) ? saved_q : hist_cur;
  assign addr_sh = addr_q >> pc_shift_q;
  assign m_sh    = addr_sh[IdxW-1:0] << h_eff;
  assign idx     = m_sh | IdxW'(n_src & hmask);

  // Prediction: always taken for an unconditional branch, else the counter's top bit on a lookup.
  assign pred = (mode_q == ModeUncond) || ((mode_q == ModeLookup) && rd_q[COUNTER_BITS-1]);

  // History update per operation.
  always_comb begin
    hist_new = hist_cur;
    hist_we  = 1'b0;
    train    = 1'b0;
    case (mode_q)
      ModeLookup, ModeUncond: begin
        hist_new = {hist_cur[HistW-2:0], pred} & hmask;
        hist_we  = 1'b1;
      end
      ModeResolve: begin
        if (squashed_q) begin
          hist_new = {saved_q[HistW-2:0], taken_q} & hmask;
          hist_we  = 1'b1;
        end else begin
          train = 1'b1;
        end
      end
      ModeRestore: begin
        hist_new = saved_q;
        hist_we  = 1'b1;
      end
      ModeBtbMiss: begin
        hist_new = hist_cur & hmask & ~HistW'(1);
        hist_we  = 1'b1;
      end
      default: ;
    endcase
  end

  // Saturating counter step.
  always_comb begin
    cnt_new = rd_q;
    if (taken_q) begin
      if (rd_q != '1) begin
        cnt_new = rd_q + COUNTER_BITS'(1);
      end
    end else if (rd_q != '0) begin
      cnt_new = rd_q - COUNTER_BITS'(1);
    end
  end

  // Per-thread history registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREADS; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cmd_i.commit && thread_ok && hist_we) begin
      hist_q[thr] <= hist_new;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + IdxW'(1);
    end
  end

  // Counter table: one write port, one registered read port.
  assign mem_we    = cmd_i.clear || (cmd_i.commit && thread_ok && train);
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : idx_q;
  assign mem_wdata = cmd_i.clear ? '0 : cnt_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rd_q  <= mem[idx];
      idx_q <= idx;
    end
  end

  // Result register; an invalid thread gives all-zero fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pred_q <= thread_ok && pred;
      snap_q <= hist_cur;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign predict_taken_o    = pred_q;
  assign history_snapshot_o = snap_q;

  assign sts_o.clr_last = (clr_cnt_q == IdxW'(Depth - 1));
  assign sts_o.out_full = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

/* sv/gselect_branch_predictor_core.sv */
// ----------------------------------------------------------------------------
// gselect_branch_predictor_core
// Gselect branch predictor with one global history register per thread and a
// table of saturating counters indexed by address bits above history bits.
// ----------------------------------------------------------------------------
// Each item passes through an accept state, a read state that forms the table
// index and reads the counter table, and an update state that updates the
// history or the counter and loads the result register, waiting there while
// an earlier result is not taken. One item is worked on at a time, so the
// block takes no new item until it has finished the last one.
// After reset the block runs a clearing pass over the counter table, one
// entry per cycle (2**floor(log2(TABLE_ENTRIES)) entries, 4096 by default),
// during which in_ready_o stays low; configuration writes are taken anytime.
`default_nettype none

module gselect_branch_predictor_core #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int COUNTER_BITS  = 2,
  parameter int THREADS       = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gbp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [gbp_pkg::ModeW-1:0]     mode_i,
  input  wire logic [gbp_pkg::ThreadW-1:0]   thread_i,
  input  wire logic [gbp_pkg::AddrW-1:0]     branch_addr_i,
  input  wire logic                          taken_i,
  input  wire logic                          squashed_i,
  input  wire logic [gbp_pkg::HistW-1:0]     saved_history_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               predict_taken_o,
  output logic [gbp_pkg::HistW-1:0]          history_snapshot_o
);
  import gbp_pkg::*;

  gbp_cmd_t cmd;
  gbp_sts_t sts;

  // Sequencer.
  gbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  gbp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNTER_BITS  (COUNTER_BITS),
    .THREADS       (THREADS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .mode_i             (mode_i),
    .thread_i           (thread_i),
    .branch_addr_i      (branch_addr_i),
    .taken_i            (taken_i),
    .squashed_i         (squashed_i),
    .saved_history_i    (saved_history_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .predict_taken_o    (predict_taken_o),
    .history_snapshot_o (history_snapshot_o)
  );

endmodule

`default_nettype wire

/* sv/gbp_checker.sv */
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks of the predictor's handshakes and item timing, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic                        predict_taken_o,
  input wire logic [gbp_pkg::HistW-1:0]   history_snapshot_o
);

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(predict_taken_o) && $stable(history_snapshot_o))
    else $error("result changed while stalled");

  // Only one item is in flight: ready drops right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // Ready drops only because an item was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("ready dropped without an accept");

  // A result rises only after an accepted item has gone through the read and update states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 3))
    else $error("result without a matching accepted item");

endmodule

bind gselect_branch_predictor_core gbp_checker u_gbp_checker (.*);

`default_nettype wire
